// ===== src/sesp_pkg.sv =====
`default_nettype none

package sesp_pkg;

  localparam int unsigned MODULE_COUNT_DEF  = 6;
  localparam int unsigned CHANNEL_COUNT_DEF = 32;

  localparam logic [31:0]        USEC_MAX   = 32'd999999;
  localparam logic signed [20:0] USEC_PER_S = 21'sd1000000;

  typedef enum logic [1:0] {
    KIND_SCALER = 2'd0,
    KIND_LATCH  = 2'd1,
    KIND_TIME   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_INDEX     = 2'd1,
    ERR_SUB_OVER  = 2'd2,
    ERR_EVT_OVER  = 2'd3
  } err_e;

  typedef struct packed {
    kind_e              kind;
    err_e               error_code;
    logic [31:0]        event_number;
    logic [15:0]        group_index;
    logic [15:0]        item_index;
    logic [63:0]        value;
    logic signed [63:0] delta;
    logic               delta_valid;
  } res_t;

endpackage

`default_nettype wire

// ===== src/sesp_if.sv =====
`default_nettype none

interface sesp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface sesp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         error_code;
  logic [31:0]        event_number;
  logic [15:0]        group_index;
  logic [15:0]        item_index;
  logic [63:0]        value;
  logic signed [63:0] delta;
  logic               delta_valid;

  modport source (output valid, output kind, output error_code, output event_number,
                  output group_index, output item_index, output value, output delta,
                  output delta_valid, input ready);
  modport sink   (input valid, input kind, input error_code, input event_number,
                  input group_index, input item_index, input value, input delta,
                  input delta_valid, output ready);
endinterface

`default_nettype wire

// ===== src/sesp_scaler_store.sv =====
`default_nettype none

module sesp_scaler_store #(
  parameter int unsigned DEPTH = 192,
  parameter int unsigned IDXW  = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic            wr_en_i,
  input  wire logic [IDXW-1:0] idx_i,
  input  wire logic [63:0]     wr_data_i,
  output logic [63:0]          rd_data_o
);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] written_q;
  logic [63:0]      rd_data_q;
  logic             rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[idx_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[idx_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : 64'd0;

endmodule

`default_nettype wire

// ===== src/sesp_parser.sv =====
`default_nettype none

module sesp_parser
  import sesp_pkg::*;
#(
  parameter int unsigned MODULE_COUNT  = MODULE_COUNT_DEF,
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned IDXW          = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [31:0]     word_i,
  output logic                 has_res_o,
  output res_t                 res_o,
  output logic                 st_rd_en_o,
  output logic                 st_wr_en_o,
  output logic [IDXW-1:0]      st_idx_o,
  output logic [63:0]          st_wr_data_o,
  input  wire logic [63:0]     st_rd_data_i
);

  localparam logic [3:0] PH_LEN       = 4'd0;
  localparam logic [3:0] PH_EVNUM     = 4'd1;
  localparam logic [3:0] PH_SPARE     = 4'd2;
  localparam logic [3:0] PH_SUBCNT    = 4'd3;
  localparam logic [3:0] PH_SUBID     = 4'd4;
  localparam logic [3:0] PH_SUBSIZE   = 4'd5;
  localparam logic [3:0] PH_SC_MODS   = 4'd6;
  localparam logic [3:0] PH_SC_CHANS  = 4'd7;
  localparam logic [3:0] PH_SC_HIGH   = 4'd8;
  localparam logic [3:0] PH_SC_LOW    = 4'd9;
  localparam logic [3:0] PH_LA_GROUPS = 4'd10;
  localparam logic [3:0] PH_LA_COUNT  = 4'd11;
  localparam logic [3:0] PH_LA_WORD   = 4'd12;
  localparam logic [3:0] PH_TS_SEC    = 4'd13;
  localparam logic [3:0] PH_TS_USEC   = 4'd14;
  localparam logic [3:0] PH_SKIP      = 4'd15;

  localparam logic [1:0] SUB_OTHER  = 2'd0;
  localparam logic [1:0] SUB_TIME   = 2'd1;
  localparam logic [1:0] SUB_LATCH  = 2'd2;
  localparam logic [1:0] SUB_SCALER = 2'd3;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  logic [3:0]         phase_q, phase_d;
  logic [31:0]        ev_left_q, ev_left_d;
  logic [31:0]        sub_left_q, sub_left_d;
  logic [31:0]        sw_left_q, sw_left_d;
  logic [1:0]         sub_kind_q, sub_kind_d;
  logic [31:0]        groups_q, groups_d;
  logic [31:0]        items_q, items_d;
  logic [15:0]        gcnt_q, gcnt_d;
  logic [15:0]        icnt_q, icnt_d;
  logic [31:0]        high_q, high_d;
  logic [31:0]        cur_evt_q, cur_evt_d;
  logic [31:0]        last_sec_q, last_sec_d;
  logic [19:0]        last_us_q, last_us_d;
  logic [31:0]        sec_hold_q, sec_hold_d;
  logic signed [32:0] dsec_q, dsec_d;

  logic               in_range;
  logic [31:0]        flat_idx;
  logic [63:0]        sc_val;
  logic [19:0]        usec;
  logic signed [53:0] sec_prod;
  logic signed [20:0] usec_diff;
  res_t               res;
  logic               has_res;

  assign in_range = (gcnt_q < 16'(MODULE_COUNT)) && (icnt_q < 16'(CHANNEL_COUNT));
  assign flat_idx = {16'd0, gcnt_q} * 32'(CHANNEL_COUNT) + {16'd0, icnt_q};
  assign sc_val   = {high_q, word_i};
  assign usec     = (word_i > USEC_MAX) ? USEC_MAX[19:0] : word_i[19:0];
  assign sec_prod  = dsec_q * USEC_PER_S;
  assign usec_diff = $signed({1'b0, usec}) - $signed({1'b0, last_us_q});

  assign st_idx_o     = flat_idx[IDXW-1:0];
  assign st_rd_en_o   = accept_i && (phase_q == PH_SC_HIGH) && in_range;
  assign st_wr_en_o   = accept_i && (phase_q == PH_SC_LOW) && in_range;
  assign st_wr_data_o = sc_val;

  always_comb begin
    phase_d    = phase_q;
    ev_left_d  = ev_left_q;
    sub_left_d = sub_left_q;
    sw_left_d  = sw_left_q;
    sub_kind_d = sub_kind_q;
    groups_d   = groups_q;
    items_d    = items_q;
    gcnt_d     = gcnt_q;
    icnt_d     = icnt_q;
    high_d     = high_q;
    cur_evt_d  = cur_evt_q;
    last_sec_d = last_sec_q;
    last_us_d  = last_us_q;
    sec_hold_d = sec_hold_q;
    dsec_d     = dsec_q;
    has_res    = 1'b0;
    res        = '0;

    if (phase_q == PH_LEN) begin
      ev_left_d = word_i;
      sw_left_d = '0;
      if (word_i == 32'd0) begin
        has_res          = 1'b1;
        res.kind         = KIND_ERROR;
        res.error_code   = ERR_EVT_OVER;
        res.group_index  = gcnt_d;
        res.item_index   = icnt_d;
      end else begin
        phase_d = PH_EVNUM;
      end
    end else begin
      ev_left_d = ev_left_q - 32'd1;
      case (phase_q)
        PH_EVNUM: begin
          cur_evt_d = word_i;
          phase_d   = PH_SPARE;
        end
        PH_SPARE: begin
          phase_d = PH_SUBCNT;
        end
        PH_SUBCNT: begin
          sub_left_d = word_i;
          sw_left_d  = '0;
          phase_d    = (word_i != 32'd0) ? PH_SUBID : PH_SKIP;
        end
        PH_SUBID: begin
          sub_kind_d = (word_i == 32'd1 || word_i == 32'd2 || word_i == 32'd3) ?
                       word_i[1:0] : SUB_OTHER;
          sub_left_d = sub_left_q - 32'd1;
          phase_d    = PH_SUBSIZE;
        end
        PH_SUBSIZE: begin
          sw_left_d = word_i;
          gcnt_d    = '0;
          icnt_d    = '0;
          if (word_i == 32'd0) begin
            if (sub_kind_q != SUB_OTHER) begin
              has_res         = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_code  = ERR_SUB_OVER;
            end
            sw_left_d = '0;
            phase_d   = (sub_left_q == 32'd0) ? PH_SKIP : PH_SUBID;
          end else begin
            case (sub_kind_q)
              SUB_SCALER: phase_d = PH_SC_MODS;
              SUB_LATCH:  phase_d = PH_LA_GROUPS;
              SUB_TIME:   phase_d = PH_TS_SEC;
              default:    phase_d = PH_SKIP;
            endcase
          end
        end
        default: begin
          if (!(phase_q == PH_SKIP && sw_left_q == 32'd0)) begin
            case (phase_q)
              PH_SC_MODS, PH_LA_GROUPS: begin
                groups_d = word_i;
                gcnt_d   = '0;
                icnt_d   = '0;
                if (word_i == 32'd0) begin
                  phase_d = PH_SKIP;
                end else begin
                  phase_d = (phase_q == PH_SC_MODS) ? PH_SC_CHANS : PH_LA_COUNT;
                end
              end
              PH_SC_CHANS, PH_LA_COUNT: begin
                items_d = word_i;
                icnt_d  = '0;
                if (word_i == 32'd0) begin
                  gcnt_d   = sat_inc(gcnt_q);
                  groups_d = groups_q - 32'd1;
                  phase_d  = (groups_d == 32'd0) ? PH_SKIP : phase_q;
                end else begin
                  phase_d = (phase_q == PH_SC_CHANS) ? PH_SC_HIGH : PH_LA_WORD;
                end
              end
              PH_SC_HIGH: begin
                high_d  = word_i;
                phase_d = PH_SC_LOW;
              end
              PH_SC_LOW, PH_LA_WORD: begin
                has_res         = 1'b1;
                res.group_index = gcnt_q;
                res.item_index  = icnt_q;
                if (phase_q == PH_LA_WORD) begin
                  res.kind  = KIND_LATCH;
                  res.value = {32'd0, word_i};
                end else if (in_range) begin
                  res.kind  = KIND_SCALER;
                  res.value = sc_val;
                  res.delta = sc_val - st_rd_data_i;
                end else begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_INDEX;
                  res.value      = sc_val;
                end
                icnt_d  = sat_inc(icnt_q);
                items_d = items_q - 32'd1;
                if (items_d == 32'd0) begin
                  gcnt_d   = sat_inc(gcnt_q);
                  icnt_d   = '0;
                  groups_d = groups_q - 32'd1;
                  if (groups_d == 32'd0) begin
                    phase_d = PH_SKIP;
                  end else begin
                    phase_d = (phase_q == PH_SC_LOW) ? PH_SC_CHANS : PH_LA_COUNT;
                  end
                end else begin
                  phase_d = (phase_q == PH_SC_LOW) ? PH_SC_HIGH : PH_LA_WORD;
                end
              end
              PH_TS_SEC: begin
                sec_hold_d = word_i;
                dsec_d     = $signed({1'b0, word_i}) - $signed({1'b0, last_sec_q});
                phase_d    = PH_TS_USEC;
              end
              PH_TS_USEC: begin
                gcnt_d         = '0;
                icnt_d         = '0;
                has_res        = 1'b1;
                res.kind       = KIND_TIME;
                res.value      = {32'd0, sec_hold_q};
                if (last_sec_q != 32'd0) begin
                  res.delta       = 64'(sec_prod) + 64'(usec_diff);
                  res.delta_valid = 1'b1;
                end
                last_sec_d = sec_hold_q;
                last_us_d  = usec;
                phase_d    = PH_SKIP;
              end
              default: begin
              end
            endcase
            sw_left_d = sw_left_q - 32'd1;
            if (sw_left_d == 32'd0) begin
              if (phase_d != PH_SKIP) begin
                has_res         = 1'b1;
                res             = '0;
                res.kind        = KIND_ERROR;
                res.error_code  = ERR_SUB_OVER;
                res.group_index = gcnt_d;
                res.item_index  = icnt_d;
              end
              phase_d = (sub_left_q == 32'd0) ? PH_SKIP : PH_SUBID;
            end
          end
        end
      endcase
      if (ev_left_d == 32'd0) begin
        if (!(phase_d == PH_SKIP && sw_left_d == 32'd0)) begin
          has_res         = 1'b1;
          res             = '0;
          res.kind        = KIND_ERROR;
          res.error_code  = ERR_EVT_OVER;
          res.group_index = gcnt_d;
          res.item_index  = icnt_d;
        end
        phase_d   = PH_LEN;
        sw_left_d = '0;
      end
    end
    res.event_number = cur_evt_d;
  end

  assign has_res_o = has_res;
  assign res_o     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN;
      ev_left_q  <= '0;
      sub_left_q <= '0;
      sw_left_q  <= '0;
      sub_kind_q <= SUB_OTHER;
      groups_q   <= '0;
      items_q    <= '0;
      gcnt_q     <= '0;
      icnt_q     <= '0;
      high_q     <= '0;
      cur_evt_q  <= '0;
      last_sec_q <= '0;
      last_us_q  <= '0;
      sec_hold_q <= '0;
      dsec_q     <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      ev_left_q  <= ev_left_d;
      sub_left_q <= sub_left_d;
      sw_left_q  <= sw_left_d;
      sub_kind_q <= sub_kind_d;
      groups_q   <= groups_d;
      items_q    <= items_d;
      gcnt_q     <= gcnt_d;
      icnt_q     <= icnt_d;
      high_q     <= high_d;
      cur_evt_q  <= cur_evt_d;
      last_sec_q <= last_sec_d;
      last_us_q  <= last_us_d;
      sec_hold_q <= sec_hold_d;
      dsec_q     <= dsec_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/sesp_out_buf.sv =====
`default_nettype none

module sesp_out_buf
  import sesp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_ready_i,
  output res_t      res_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q;
  res_t       tail_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign ready_o = (cnt_q != 2'd2);
  assign pop     = valid_o && pop_ready_i;
  assign res_o   = head_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        head_q <= tail_q;
      end else if (push_i) begin
        head_q <= res_i;
      end
    end else if (push_i && cnt_q == 2'd0) begin
      head_q <= res_i;
    end
    if (push_i && !pop && cnt_q == 2'd1) begin
      tail_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/scaler_event_stream_parser_top.sv =====
// Scaler event stream parser.
// in_i carries one 32-bit stream word per transaction (valid/ready); out_o
// carries at most one result per input word: scaler value with delta, latch
// word, timestamp with microsecond difference, or an error report.
// Each accepted word is parsed in the cycle it is accepted; its result, if
// any, is registered in the output buffer and shown on out_o behind any
// earlier results still waiting. Throughput is one word per cycle while the
// output buffer has room. The scaler table is one memory read on the high
// word of a pair and one write on the low word, so a pair flows at that rate.
// A two-entry result buffer sits at the output: while the receiver stalls,
// input keeps flowing until both entries are full, then ready drops.
// Reset puts the parser back to waiting for a length word, clears all
// counters and the previous timestamp, and marks every scaler entry as zero
// at once; the block is ready for words as soon as reset is released.
`default_nettype none

module scaler_event_stream_parser_top
  import sesp_pkg::*;
#(
  parameter int unsigned MODULE_COUNT  = MODULE_COUNT_DEF,
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sesp_in_if.sink      in_i,
  sesp_out_if.source   out_o
);

  localparam int unsigned DEPTH = MODULE_COUNT * CHANNEL_COUNT;
  localparam int unsigned IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic            accept;
  logic            buf_ready;
  logic            has_res;
  res_t            res;
  res_t            out_res;
  logic            st_rd_en;
  logic            st_wr_en;
  logic [IDXW-1:0] st_idx;
  logic [63:0]     st_wr_data;
  logic [63:0]     st_rd_data;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  sesp_parser #(
    .MODULE_COUNT (MODULE_COUNT),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .IDXW         (IDXW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (in_i.data_word),
    .has_res_o   (has_res),
    .res_o       (res),
    .st_rd_en_o  (st_rd_en),
    .st_wr_en_o  (st_wr_en),
    .st_idx_o    (st_idx),
    .st_wr_data_o(st_wr_data),
    .st_rd_data_i(st_rd_data)
  );

  sesp_scaler_store #(
    .DEPTH(DEPTH),
    .IDXW (IDXW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (st_rd_en),
    .wr_en_i  (st_wr_en),
    .idx_i    (st_idx),
    .wr_data_i(st_wr_data),
    .rd_data_o(st_rd_data)
  );

  sesp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && has_res),
    .res_i      (res),
    .ready_o    (buf_ready),
    .valid_o    (out_o.valid),
    .pop_ready_i(out_o.ready),
    .res_o      (out_res)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.error_code   = out_res.error_code;
  assign out_o.event_number = out_res.event_number;
  assign out_o.group_index  = out_res.group_index;
  assign out_o.item_index   = out_res.item_index;
  assign out_o.value        = out_res.value;
  assign out_o.delta        = out_res.delta;
  assign out_o.delta_valid  = out_res.delta_valid;

endmodule

`default_nettype wire
